// ----- src/irft_pkg.sv -----
// shared types, constants and register codes of the infrared remote frame transmitter
package irft_pkg;

  localparam int PIN_COUNT = 12;
  localparam int NEC_BITS  = 32;
  localparam int RC5_BITS  = 14;

  localparam int DUR_W   = 17;
  localparam int SEG_W   = 7;
  localparam int CODE_W  = 32;
  localparam int FRAME_W = 5;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [PIN_COUNT-1:0] ALL_PINS = {PIN_COUNT{1'b1}};
  localparam logic [CODE_W-1:0] RC5_CODE_MASK  = 32'h0000_37FF;
  localparam logic [CODE_W-1:0] RC5_TOGGLE_BIT = 32'h0000_0800;

  localparam logic [SEG_W-1:0] NEC_STOP_IDX = SEG_W'(2 + 2 * NEC_BITS);
  localparam logic [SEG_W-1:0] NEC_GAP_IDX  = SEG_W'(3 + 2 * NEC_BITS);
  localparam logic [SEG_W-1:0] RC5_GAP_IDX  = SEG_W'(2 * RC5_BITS);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NEC_HDR_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEC_HDR_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEC_UNIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEC_ONE_SPACE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RC5_HALF_BIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP     = 3'd5;

  localparam logic [15:0] RST_NEC_HDR_MARK  = 16'd9000;
  localparam logic [15:0] RST_NEC_HDR_SPACE = 16'd4500;
  localparam logic [11:0] RST_NEC_UNIT      = 12'd562;
  localparam logic [12:0] RST_NEC_ONE_SPACE = 13'd1687;
  localparam logic [11:0] RST_RC5_HALF_BIT  = 12'd887;
  localparam logic [16:0] RST_FRAME_GAP     = 17'd88000;

  localparam logic PROTO_NEC = 1'b0;
  localparam logic PROTO_RC5 = 1'b1;
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOW   = 2'd0,
    MODE_HIGH  = 2'd1,
    MODE_FLOAT = 2'd2
  } mode_t;

  typedef struct packed {
    logic [15:0] nec_header_mark_us;
    logic [15:0] nec_header_space_us;
    logic [11:0] nec_unit_us;
    logic [12:0] nec_one_space_us;
    logic [11:0] rc5_half_bit_us;
    logic [16:0] frame_gap_us;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic [DUR_W-1:0] len;
  } seg_t;

endpackage

// ----- src/irft_in_if.sv -----
// input channel: start and tick words
interface irft_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic                            protocol;
  logic [31:0]                     key_code;
  logic [irft_pkg::PIN_COUNT-1:0]  target_pins;
  logic [4:0]                      repeat_count;

  modport source (output valid, cmd, protocol, key_code, target_pins, repeat_count,
                  input ready);
  modport sink (input valid, cmd, protocol, key_code, target_pins, repeat_count,
                output ready);
endinterface

// ----- src/irft_out_if.sv -----
// output channel: pin state words
interface irft_out_if;
  logic                            valid;
  logic                            ready;
  logic [irft_pkg::PIN_COUNT-1:0]  pin_levels;
  logic [irft_pkg::PIN_COUNT-1:0]  pin_driven;
  logic                            busy_res;

  modport source (output valid, pin_levels, pin_driven, busy_res, input ready);
  modport sink (input valid, pin_levels, pin_driven, busy_res, output ready);
endinterface

// ----- src/irft_segment_decode.sv -----
// segment decoder: line mode and length of one frame segment
module irft_segment_decode (
  input  logic                           proto,
  input  logic [irft_pkg::SEG_W-1:0]     seg_idx,
  input  logic [irft_pkg::CODE_W-1:0]    code,
  input  irft_pkg::cfg_t                 cfg,
  output irft_pkg::seg_t                 seg
);

  logic [irft_pkg::SEG_W-1:0] k;
  logic [4:0]                 nec_pos;
  logic [4:0]                 rc5_pos;
  logic [irft_pkg::DUR_W-1:0] len_raw;
  logic                       code_bit;

  assign k       = seg_idx - irft_pkg::SEG_W'(2);
  assign nec_pos = 5'(irft_pkg::NEC_BITS - 1) - k[5:1];
  assign rc5_pos = 5'(irft_pkg::RC5_BITS - 1) - seg_idx[5:1];

  always_comb begin
    code_bit = 1'b0;
    len_raw  = '0;
    seg.mode = irft_pkg::MODE_FLOAT;
    if (proto == irft_pkg::PROTO_NEC) begin
      if (seg_idx == '0) begin
        seg.mode = irft_pkg::MODE_LOW;
        len_raw  = 17'(cfg.nec_header_mark_us);
      end else if (seg_idx == irft_pkg::SEG_W'(1)) begin
        seg.mode = irft_pkg::MODE_HIGH;
        len_raw  = 17'(cfg.nec_header_space_us);
      end else if (seg_idx < irft_pkg::NEC_STOP_IDX) begin
        if (!k[0]) begin
          seg.mode = irft_pkg::MODE_LOW;
          len_raw  = 17'(cfg.nec_unit_us);
        end else begin
          code_bit = code[nec_pos];
          seg.mode = irft_pkg::MODE_HIGH;
          len_raw  = code_bit ? 17'(cfg.nec_one_space_us) : 17'(cfg.nec_unit_us);
        end
      end else if (seg_idx == irft_pkg::NEC_STOP_IDX) begin
        seg.mode = irft_pkg::MODE_LOW;
        len_raw  = 17'(cfg.nec_unit_us);
      end else begin
        len_raw = cfg.frame_gap_us;
      end
    end else begin
      if (seg_idx < irft_pkg::RC5_GAP_IDX) begin
        // manchester: a one is high then low
        code_bit = code[rc5_pos];
        seg.mode = (code_bit ^ seg_idx[0]) ? irft_pkg::MODE_HIGH : irft_pkg::MODE_LOW;
        len_raw  = 17'(cfg.rc5_half_bit_us);
      end else begin
        len_raw = cfg.frame_gap_us;
      end
    end
    seg.len = (len_raw == '0) ? irft_pkg::DUR_W'(1) : len_raw;
  end

endmodule

// ----- src/ir_remote_frame_transmitter.sv -----
// top level: infrared remote line driver for nec and rc5 frames
// Drives a bank of 12 pins with NEC pulse-distance or RC5 Manchester frames.
// A start word latches protocol, code, pin mask and frame count; every tick
// word advances line time by one microsecond. Each input word, start or tick,
// yields exactly one output word showing the pins after that word took
// effect. One word is taken every clock cycle, held back only by output stalls:
// the segment step is a single decode and a 17-bit down count between the state
// registers and the output register, so each output word is registered in the
// cycle after its input word is taken. Durations come from
// the configuration registers; write them only while the block is idle.
// A start while busy is ignored and simply reports the current pins.
module ir_remote_frame_transmitter (
  input  logic                              clk,
  input  logic                              rst,
  irft_in_if.sink                           in_ch,
  irft_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [irft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irft_pkg::CFG_W-1:0]        cfg_data
);

  localparam int PW = irft_pkg::PIN_COUNT;

  // configuration
  irft_pkg::cfg_t cfg;

  // transmitter state
  logic [irft_pkg::DUR_W-1:0]   dur, dur_next;
  logic [irft_pkg::SEG_W-1:0]   seg_idx, seg_idx_next;
  logic [irft_pkg::CODE_W-1:0]  code, code_next;
  logic [irft_pkg::FRAME_W-1:0] frames, frames_next;
  logic                         toggle, toggle_next;
  logic                         proto, proto_next;
  logic [PW-1:0]                pins, pins_next;
  logic [PW-1:0]                level, level_next;
  logic [PW-1:0]                drive, drive_next;

  // output register
  logic          out_valid;
  logic [PW-1:0] out_level;
  logic [PW-1:0] out_drive;
  logic          out_busy;

  logic accept;

  // segment decode inputs and helpers
  logic                         dec_proto;
  logic [irft_pkg::SEG_W-1:0]   dec_idx;
  logic [irft_pkg::CODE_W-1:0]  dec_code;
  irft_pkg::seg_t               seg;
  logic [irft_pkg::DUR_W-1:0]   dur_dec;
  logic [irft_pkg::SEG_W-1:0]   seg_inc;
  logic [irft_pkg::FRAME_W-1:0] frames_dec;
  logic                         frame_done;
  logic                         do_start;
  logic                         enter;
  logic [PW-1:0]                base_level;
  logic [PW-1:0]                base_drive;
  logic [irft_pkg::CODE_W-1:0]  start_code;
  logic                         start_toggle;

  // a skid-free output register: take a word whenever the slot is free or leaving
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid;
  assign out_ch.pin_levels = out_level;
  assign out_ch.pin_driven = out_drive;
  assign out_ch.busy_res   = out_busy;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nec_header_mark_us  <= irft_pkg::RST_NEC_HDR_MARK;
      cfg.nec_header_space_us <= irft_pkg::RST_NEC_HDR_SPACE;
      cfg.nec_unit_us         <= irft_pkg::RST_NEC_UNIT;
      cfg.nec_one_space_us    <= irft_pkg::RST_NEC_ONE_SPACE;
      cfg.rc5_half_bit_us     <= irft_pkg::RST_RC5_HALF_BIT;
      cfg.frame_gap_us        <= irft_pkg::RST_FRAME_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irft_pkg::REG_NEC_HDR_MARK:  cfg.nec_header_mark_us  <= cfg_data[15:0];
        irft_pkg::REG_NEC_HDR_SPACE: cfg.nec_header_space_us <= cfg_data[15:0];
        irft_pkg::REG_NEC_UNIT:      cfg.nec_unit_us         <= cfg_data[11:0];
        irft_pkg::REG_NEC_ONE_SPACE: cfg.nec_one_space_us    <= cfg_data[12:0];
        irft_pkg::REG_RC5_HALF_BIT:  cfg.rc5_half_bit_us     <= cfg_data[11:0];
        irft_pkg::REG_FRAME_GAP:     cfg.frame_gap_us        <= cfg_data;
        default: ;
      endcase
    end
  end

  // start word decode: rc5 code gets masked and the toggle bit
  assign start_toggle = (in_ch.protocol == irft_pkg::PROTO_RC5) ? !toggle : toggle;
  always_comb begin
    if (in_ch.protocol == irft_pkg::PROTO_NEC) begin
      start_code = in_ch.key_code;
    end else begin
      start_code = (in_ch.key_code & irft_pkg::RC5_CODE_MASK)
                 | (start_toggle ? irft_pkg::RC5_TOGGLE_BIT : '0);
    end
  end

  assign do_start   = (in_ch.cmd == irft_pkg::CMD_START) && (frames == '0);
  assign dur_dec    = dur - irft_pkg::DUR_W'(1);
  assign seg_inc    = seg_idx + irft_pkg::SEG_W'(1);
  assign frames_dec = frames - irft_pkg::FRAME_W'(1);

  // rc5 skips the trailing gap on the last frame
  always_comb begin
    if (proto == irft_pkg::PROTO_NEC) begin
      frame_done = seg_inc > irft_pkg::NEC_GAP_IDX;
    end else begin
      frame_done = (seg_inc > irft_pkg::RC5_GAP_IDX)
                || (seg_inc == irft_pkg::RC5_GAP_IDX && frames == irft_pkg::FRAME_W'(1));
    end
  end

  // one decoder serves both a fresh start and a segment boundary
  assign dec_proto = do_start ? in_ch.protocol : proto;
  assign dec_idx   = (do_start || frame_done) ? '0 : seg_inc;
  assign dec_code  = do_start ? start_code : code;

  irft_segment_decode u_seg (
    .proto   (dec_proto),
    .seg_idx (dec_idx),
    .code    (dec_code),
    .cfg     (cfg),
    .seg     (seg)
  );

  always_comb begin
    dur_next     = dur;
    seg_idx_next = seg_idx;
    code_next    = code;
    frames_next  = frames;
    toggle_next  = toggle;
    proto_next   = proto;
    pins_next    = pins;
    base_level   = level;
    base_drive   = drive;
    enter        = 1'b0;

    if (in_ch.cmd == irft_pkg::CMD_START) begin
      if (do_start) begin
        proto_next   = in_ch.protocol;
        pins_next    = in_ch.target_pins;
        frames_next  = (in_ch.repeat_count == '0) ? irft_pkg::FRAME_W'(1)
                                                  : in_ch.repeat_count;
        code_next    = start_code;
        toggle_next  = start_toggle;
        seg_idx_next = '0;
        base_level   = irft_pkg::ALL_PINS;
        base_drive   = irft_pkg::ALL_PINS;
        enter        = 1'b1;
      end
    end else if (frames != '0) begin
      dur_next = dur_dec;
      if (dur_dec == '0) begin
        if (!frame_done) begin
          seg_idx_next = seg_inc;
          enter        = 1'b1;
        end else begin
          frames_next  = frames_dec;
          seg_idx_next = '0;
          if (frames_dec == '0) begin
            // last frame over: lines back to idle high
            base_level = irft_pkg::ALL_PINS;
            base_drive = irft_pkg::ALL_PINS;
          end else begin
            if (proto == irft_pkg::PROTO_NEC) begin
              base_level = irft_pkg::ALL_PINS;
              base_drive = irft_pkg::ALL_PINS;
            end
            enter = 1'b1;
          end
        end
      end
    end

    level_next = base_level;
    drive_next = base_drive;
    if (enter) begin
      dur_next = seg.len;
      unique case (seg.mode)
        irft_pkg::MODE_LOW: begin
          drive_next = base_drive | pins_next;
          level_next = base_level & ~pins_next;
        end
        irft_pkg::MODE_HIGH: begin
          drive_next = base_drive | pins_next;
          level_next = base_level | pins_next;
        end
        default: begin
          drive_next = base_drive & ~pins_next;
          level_next = base_level & ~pins_next;
        end
      endcase
    end
  end

  // state update on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      dur     <= '0;
      seg_idx <= '0;
      code    <= '0;
      frames  <= '0;
      toggle  <= 1'b0;
      proto   <= irft_pkg::PROTO_NEC;
      pins    <= '0;
      level   <= '0;
      drive   <= '0;
    end else if (accept) begin
      dur     <= dur_next;
      seg_idx <= seg_idx_next;
      code    <= code_next;
      frames  <= frames_next;
      toggle  <= toggle_next;
      proto   <= proto_next;
      pins    <= pins_next;
      level   <= level_next;
      drive   <= drive_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_level <= level_next;
      out_drive <= drive_next;
      out_busy  <= (frames_next != '0);
    end
  end

`ifndef NO_ASSERTIONS
  // a pin reads high only while it is driven
  a_level_needs_drive: assert property (@(posedge clk) disable iff (rst)
    (level & ~drive) == '0)
    else $error("pin high while floating");

  // idle lines are uniform: all low after reset or all driven high
  a_idle_uniform: assert property (@(posedge clk) disable iff (rst)
    (frames == '0) |-> (level == drive))
    else $error("idle pins not uniform");

  // a running transmission always has time left in its segment
  a_busy_has_time: assert property (@(posedge clk) disable iff (rst)
    (frames != '0) |-> (dur != '0))
    else $error("busy with empty segment");

  // ticks while idle leave the pins alone
  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.cmd == irft_pkg::CMD_TICK && frames == '0) |=>
      ($stable(level) && $stable(drive) && frames == '0))
    else $error("idle tick changed pins");
`endif

endmodule
